// ===== hw/rtl/kmlp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmlp_pkg
// Shared types, character codes and helpers for the keyboard macro line parser.
// ----------------------------------------------------------------------------
package kmlp_pkg;

  // Field widths of the byte stream and the command stream.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ActionW = 2;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned NibW    = 4;

  // Packed data widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = ByteW;
  localparam int unsigned OutFldW  = ActionW + CodeW;
  localparam int unsigned OutDataW = ((OutFldW + 7) / 8) * 8;

  // Default limit on hex digits in one line.
  localparam int unsigned MaxDigitsDefault = 8;

  // Characters that steer the parser.
  localparam logic [ByteW-1:0] ChPress   = 8'h70;  // 'p'
  localparam logic [ByteW-1:0] ChRelease = 8'h72;  // 'r'
  localparam logic [ByteW-1:0] ChDelay   = 8'h74;  // 't'
  localparam logic [ByteW-1:0] ChComma   = 8'h2C;  // ','
  localparam logic [ByteW-1:0] ChNewline = 8'h0A;  // '\n'

  // Command selected by the script; none until a letter is seen.
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_DELAY   = 2'd3
  } kind_e;

  // Action code carried on the output stream.
  typedef enum logic [ActionW-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_DELAY   = 2'd2
  } action_e;

  // Decoded view of one script byte.
  typedef struct packed {
    logic            is_hex;
    logic [NibW-1:0] nib;
  } hex_t;

  // Turn an ASCII hex digit into its nibble value.
  function automatic hex_t hex_decode(logic [ByteW-1:0] b);
    hex_t r;
    r.is_hex = 1'b0;
    r.nib    = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.is_hex = 1'b1;
      r.nib    = NibW'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.is_hex = 1'b1;
      r.nib    = NibW'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.is_hex = 1'b1;
      r.nib    = NibW'(b - 8'h37);
    end
    return r;
  endfunction

  // Map a selected command to the action code that is issued.
  function automatic action_e kind_to_action(kind_e k);
    action_e a;
    case (k)
      KIND_RELEASE: a = ACT_RELEASE;
      KIND_DELAY:   a = ACT_DELAY;
      default:      a = ACT_PRESS;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/key_macro_line_parser.sv =====
// ----------------------------------------------------------------------------
// key_macro_line_parser
// Parses a keyboard macro script, one byte per word, into press, release and
// delay commands with a 16-bit code.
// ----------------------------------------------------------------------------
// The block takes one script byte per cycle and issues at most one command
// per byte, and the command is issued in the cycle after the byte is taken.
// The rate is one byte per cycle, set by the single parse step between the
// input handshake and the output register, which keeps accepting bytes as
// long as the output register is empty or being drained in the same cycle.
// Letters p, r and t pick the command, a comma is ignored, hex digits shift
// into the code, and a newline or a tlast byte that is no letter or comma
// issues the command. Lines with more than MAX_DIGITS hex digits are dropped.
module key_macro_line_parser #(
  parameter int unsigned MAX_DIGITS = kmlp_pkg::MaxDigitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Script byte stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [kmlp_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] script_byte
  input  logic                          s_axis_tlast,   // end_of_script
  // Command stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kmlp_pkg::OutDataW-1:0] m_axis_tdata    // [1:0] action, [17:2] code
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_DIGITS);

  // Parser state.
  kmlp_pkg::kind_e                 kind_q, kind_d;
  logic [kmlp_pkg::CodeW-1:0]      hex_q, hex_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            skip_q, skip_d;

  // Output register.
  logic                            out_valid_q, out_valid_d;
  kmlp_pkg::action_e               out_action_q, out_action_d;
  logic [kmlp_pkg::CodeW-1:0]      out_code_q, out_code_d;

  logic                            accept;
  logic                            emit;
  logic [kmlp_pkg::ByteW-1:0]      byte_in;
  kmlp_pkg::hex_t                  dec;
  logic                            full;
  logic [kmlp_pkg::CodeW-1:0]      hex_shift;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign byte_in       = s_axis_tdata[kmlp_pkg::ByteW-1:0];
  assign dec           = kmlp_pkg::hex_decode(byte_in);
  assign full          = (cnt_q >= CntMax);
  assign hex_shift     = {hex_q[kmlp_pkg::CodeW-kmlp_pkg::NibW-1:0], dec.nib};

  // One parse step for the byte on the input.
  always_comb begin
    kind_d = kind_q;
    hex_d  = hex_q;
    cnt_d  = cnt_q;
    skip_d = skip_q;
    emit   = 1'b0;
    out_code_d = hex_q;
    if (accept) begin
      if (skip_q) begin
        // Dropping an over-long line up to its newline.
        if (byte_in == kmlp_pkg::ChNewline) begin
          skip_d = 1'b0;
        end
      end else if (byte_in == kmlp_pkg::ChPress) begin
        kind_d = kmlp_pkg::KIND_PRESS;
      end else if (byte_in == kmlp_pkg::ChRelease) begin
        kind_d = kmlp_pkg::KIND_RELEASE;
      end else if (byte_in == kmlp_pkg::ChDelay) begin
        kind_d = kmlp_pkg::KIND_DELAY;
      end else if (byte_in == kmlp_pkg::ChComma) begin
        // A comma only separates fields.
      end else if (dec.is_hex) begin
        if (full) begin
          // Too many digits: the line is dropped.
          skip_d = 1'b1;
          hex_d  = '0;
          cnt_d  = '0;
        end else begin
          hex_d = hex_shift;
          cnt_d = cnt_q + 1'b1;
          // A digit in the last byte completes the line at once.
          if (s_axis_tlast) begin
            emit       = (kind_q != kmlp_pkg::KIND_NONE);
            out_code_d = hex_shift;
            hex_d      = '0;
            cnt_d      = '0;
          end
        end
      end else if (byte_in == kmlp_pkg::ChNewline || s_axis_tlast) begin
        // End of line issues the pending command.
        emit  = (kind_q != kmlp_pkg::KIND_NONE);
        hex_d = '0;
        cnt_d = '0;
      end
      // The end of the script clears everything but the command.
      if (s_axis_tlast) begin
        hex_d  = '0;
        cnt_d  = '0;
        skip_d = 1'b0;
      end
    end
  end

  // Output register with load on issue and clear on drain.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_action_d = kmlp_pkg::kind_to_action(kind_q);
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= kmlp_pkg::KIND_NONE;
      hex_q       <= '0;
      cnt_q       <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      kind_q      <= kind_d;
      hex_q       <= hex_d;
      cnt_q       <= cnt_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded only when a command is issued.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_action_q <= out_action_d;
      out_code_q   <= out_code_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(kmlp_pkg::OutDataW - kmlp_pkg::OutFldW){1'b0}},
                          out_code_q, out_action_q};

`ifndef SYNTHESIS
  // The digit count never passes the line limit.
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("digit count above limit");

  // While a line is dropped no digits are held.
  a_skip_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> (cnt_q == '0 && hex_q == '0))
    else $error("digits held while dropping a line");

  // A new command only appears after a byte was taken.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept))
    else $error("command issued without an input byte");

  // A byte taken while dropping a line issues nothing.
  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && skip_q) |-> !emit)
    else $error("command issued from a dropped line");
`endif

endmodule

// ===== dv/key_macro_line_parser_test.sv =====
// ----------------------------------------------------------------------------
// key_macro_line_parser_test
// Self-checking testbench for the keyboard macro line parser. A queue of
// script bytes is streamed into the block with random gaps. Every accepted
// byte runs through a local parser model, and each command word that comes
// out is checked against the oldest predicted command.
// ----------------------------------------------------------------------------
module key_macro_line_parser_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineDigits = kmlp_pkg::MaxDigitsDefault;
  localparam int unsigned RandomBytes = 600;
  localparam int unsigned CycleLimit = 400000;

  // One byte of the script as the sender presents it.
  typedef struct {
    logic [kmlp_pkg::ByteW-1:0] ch;
    bit                         last;
    bit                         drain;  // hold this byte until every command is back
  } script_byte_t;

  // One issued command.
  typedef struct {
    kmlp_pkg::action_e          action;
    logic [kmlp_pkg::CodeW-1:0] code;
  } command_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [kmlp_pkg::InDataW-1:0]  s_axis_tdata = '0;   // [7:0] script_byte
  logic                          s_axis_tlast = 1'b0; // end_of_script
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [kmlp_pkg::OutDataW-1:0] m_axis_tdata;        // [1:0] action, [17:2] code

  script_byte_t script_q[$];
  command_t     expected_cmds[$];

  // State of the local parser model.
  kmlp_pkg::kind_e            sel_kind = kmlp_pkg::KIND_NONE;
  logic [kmlp_pkg::CodeW-1:0] code_acc = '0;
  int unsigned                digit_cnt = 0;
  bit                         drop_line = 1'b0;

  int unsigned bytes_sent = 0;
  int unsigned total_bytes = 0;
  int unsigned cmds_checked = 0;
  int unsigned lines_dropped = 0;
  int unsigned scripts_built = 0;
  int unsigned mismatches = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  bit          src_burst = 1'b0;
  bit          snk_burst = 1'b0;

  key_macro_line_parser #(
    .MAX_DIGITS(LineDigits)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #4 clk_i = ~clk_i;

  // Value of a hex digit character, or -1 for any other byte.
  function automatic int digit_value(logic [kmlp_pkg::ByteW-1:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  // Ends the current line: issues the selected command, if any, and clears
  // the collected digits.
  function automatic bit close_line(output command_t cmd);
    bit issued;
    issued = 1'b0;
    cmd.action = kmlp_pkg::ACT_PRESS;
    cmd.code = code_acc;
    case (sel_kind)
      kmlp_pkg::KIND_PRESS: begin
        issued = 1'b1;
      end
      kmlp_pkg::KIND_RELEASE: begin
        cmd.action = kmlp_pkg::ACT_RELEASE;
        issued = 1'b1;
      end
      kmlp_pkg::KIND_DELAY: begin
        cmd.action = kmlp_pkg::ACT_DELAY;
        issued = 1'b1;
      end
      default: begin
        issued = 1'b0;
      end
    endcase
    code_acc = '0;
    digit_cnt = 0;
    return issued;
  endfunction

  // Advances the parser model by one byte; returns 1 when a command results.
  function automatic bit parse_byte(logic [kmlp_pkg::ByteW-1:0] b, bit last,
                                    output command_t cmd);
    int nib;
    bit issued;
    issued = 1'b0;
    cmd.action = kmlp_pkg::ACT_PRESS;
    cmd.code = '0;
    nib = digit_value(b);
    if (drop_line) begin
      if (b == kmlp_pkg::ChNewline) drop_line = 1'b0;
    end else if (b == kmlp_pkg::ChPress) begin
      sel_kind = kmlp_pkg::KIND_PRESS;
    end else if (b == kmlp_pkg::ChRelease) begin
      sel_kind = kmlp_pkg::KIND_RELEASE;
    end else if (b == kmlp_pkg::ChDelay) begin
      sel_kind = kmlp_pkg::KIND_DELAY;
    end else if (b == kmlp_pkg::ChComma) begin
      issued = 1'b0;
    end else if (nib >= 0) begin
      if (digit_cnt >= LineDigits) begin
        // Line is too long: drop it up to its newline.
        drop_line = 1'b1;
        code_acc = '0;
        digit_cnt = 0;
        lines_dropped++;
      end else begin
        code_acc = {code_acc[kmlp_pkg::CodeW-kmlp_pkg::NibW-1:0], kmlp_pkg::NibW'(nib)};
        digit_cnt++;
        if (last) issued = close_line(cmd);
      end
    end else if (last || b == kmlp_pkg::ChNewline) begin
      issued = close_line(cmd);
    end
    // The end of a script clears the line but keeps the selected command.
    if (last) begin
      code_acc = '0;
      digit_cnt = 0;
      drop_line = 1'b0;
    end
    return issued;
  endfunction

  function automatic int unsigned gap_len(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic push_byte(logic [kmlp_pkg::ByteW-1:0] ch, bit last = 1'b0,
                           bit drain = 1'b0);
    script_byte_t sb;
    sb.ch = ch;
    sb.last = last;
    sb.drain = drain;
    script_q.push_back(sb);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [kmlp_pkg::ByteW-1:0] rand_digit();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return kmlp_pkg::ByteW'(int'("0") + r);
    if (r < 16) return kmlp_pkg::ByteW'(int'("a") + r - 10);
    return kmlp_pkg::ByteW'(int'("A") + r - 16);
  endfunction

  // Builds one script of a few lines, mostly well formed with some noise.
  task automatic push_script(bit drain);
    int unsigned n_lines;
    int unsigned n_digits;
    int unsigned sel;
    n_lines = $urandom_range(1, 6);
    scripts_built++;
    for (int l = 0; l < n_lines; l++) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) push_byte(kmlp_pkg::ChPress, 1'b0, drain && l == 0);
      else if (sel < 6) push_byte(kmlp_pkg::ChRelease, 1'b0, drain && l == 0);
      else if (sel < 8) push_byte(kmlp_pkg::ChDelay, 1'b0, drain && l == 0);
      else push_byte(kmlp_pkg::ChComma, 1'b0, drain && l == 0);
      if ($urandom_range(0, 3) == 0) push_byte(kmlp_pkg::ChComma);
      n_digits = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 12)
                                              : $urandom_range(0, 8);
      for (int d = 0; d < n_digits; d++) begin
        if ($urandom_range(0, 11) == 0) push_byte(kmlp_pkg::ByteW'($urandom_range(0, 255)));
        push_byte(rand_digit());
      end
      if ($urandom_range(0, 7) == 0) push_byte(kmlp_pkg::ByteW'($urandom_range(0, 255)));
      push_byte(kmlp_pkg::ChNewline);
    end
    // Sometimes the script ends on the byte before its final newline instead.
    if ($urandom_range(0, 2) == 0) void'(script_q.pop_back());
    script_q[script_q.size()-1].last = 1'b1;
  endtask

  // Sender: presents the next queued byte after a random gap and runs each
  // accepted byte through the parser model.
  always @(posedge clk_i or negedge rst_ni) begin
    script_byte_t sb;
    command_t     cmd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_byte(s_axis_tdata, s_axis_tlast, cmd)) expected_cmds.push_back(cmd);
        bytes_sent++;
      end
      if ($urandom_range(0, 63) == 0) src_burst <= !src_burst;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (script_q.size() != 0 &&
                     (!script_q[0].drain ||
                      (expected_cmds.size() == 0 && !m_axis_tvalid))) begin
          sb = script_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= sb.ch;
          s_axis_tlast <= sb.last;
          src_gap <= gap_len(src_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks every command word it takes.
  always @(posedge clk_i or negedge rst_ni) begin
    command_t                   want;
    kmlp_pkg::action_e          got_action;
    logic [kmlp_pkg::CodeW-1:0] got_code;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_action = kmlp_pkg::action_e'(m_axis_tdata[kmlp_pkg::ActionW-1:0]);
        got_code = m_axis_tdata[kmlp_pkg::ActionW +: kmlp_pkg::CodeW];
        cmds_checked++;
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: command word with none predicted: action %0d code %h",
                     $realtime, got_action, got_code);
        end else begin
          want = expected_cmds.pop_front();
          if (got_action !== want.action || got_code !== want.code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: command mismatch: expected action %0d code %h, got %0d code %h",
                       $realtime, want.action, want.code, got_action, got_code);
          end
        end
      end
      if ($urandom_range(0, 63) == 0) snk_burst <= !snk_burst;
      if (snk_gap != 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        snk_gap <= gap_len(snk_burst);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned directed_len;

    // No command selected yet: the line issues nothing.
    push_text("5\n");
    // Comma, null and all-ones bytes inside a press line.
    push_text("p");
    push_byte(8'h00);
    push_text(",A");
    push_byte(8'hFF);
    push_text("\n");
    // Empty line issues code zero.
    push_text("r\n");
    // Nine digits overflow the line; it is dropped up to its newline.
    push_text("t123456789");
    push_byte(8'h00);
    push_text("\n");
    // Script ends on a digit, then on a letter, then on a newline.
    push_byte("a", 1'b1);
    push_byte(kmlp_pkg::ChRelease, 1'b1);
    push_byte(kmlp_pkg::ChNewline, 1'b1);
    directed_len = script_q.size();

    // The first random script waits for the block to drain.
    push_script(1'b1);
    while (script_q.size() < directed_len + RandomBytes)
      push_script($urandom_range(0, 7) == 0);
    total_bytes = script_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every queued byte has been taken by the block.
    while (bytes_sent != total_bytes) @(posedge clk_i);
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Streamed %0d bytes in %0d random scripts plus a directed set.",
             bytes_sent, scripts_built);
    $display("Checked %0d commands; %0d over-long lines were dropped, %0d mismatches.",
             cmds_checked, lines_dropped, mismatches);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (expected_cmds.size() != 0)
        $display("%0d predicted commands never arrived", expected_cmds.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timed out after %0d cycles", cycles);
    $display("TB_ERROR");
    $finish;
  end

endmodule
